// File: hdl/sism_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sparse index set merge core.
// No dependencies; imported by sism_marker and sparse_index_set_merge_core.
`default_nettype none

package sism_pkg;

  // fixed field widths
  localparam int IDX_W = 10;
  localparam int OP_W  = 3;
  localparam int ST_W  = 3;
  localparam int CNT_W = 7;
  localparam int LC_W  = 11;
  localparam int IDX_SPAN = 1 << IDX_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_MERGE     = 3'd0;
  localparam logic [OP_W-1:0] OP_EXT_MERGE = 3'd1;
  localparam logic [OP_W-1:0] OP_RESET     = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_ALL  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_NEW  = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [ST_W-1:0] ST_LOCAL    = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
  localparam logic [ST_W-1:0] ST_RESET    = 3'd5;
  localparam logic [ST_W-1:0] ST_ENTRY    = 3'd6;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd7;

  // marker memory access
  typedef struct packed {
    logic rd;   // read entry, hit valid next cycle
    logic wr;   // write entry
    logic set;  // value written
  } mark_cmd_t;

endpackage

`default_nettype wire

// File: hdl/sparse_index_set_merge_core.sv
`timescale 1ns / 1ps
// Sparse index set merge core: top level with member list and control FSM.
// Depends on sism_pkg and sism_marker.
//
// Usage:
//   s_* stream carries commands (merge, external merge, reset, read all,
//   read new); m_* stream returns result transactions. cfg_* writes the
//   local_count register and is always ready; write it only while idle.
//   Merge: accepted in S_IDLE with a marker read, marker write in S_MERGE_CHK,
//   then S_RESULT loads the result into the output register. A local or
//   out-of-range index skips the marker check and goes straight to S_RESULT.
//   Reset op: per member a list read, then a marker clear; then one result.
//   Read all / read new: per emitted member a list memory read, then an
//   output load; an empty read gives one result marked empty.
//   Command codes 5 to 7 are dropped without a result.
//   After rst the marker memory is swept, one entry per cycle, over all
//   min(INDEX_RANGE, 1024) entries; s_tready stays low during the sweep.
//   A stalled m_tready holds the output register; the core accepts the next
//   command while a result waits and stalls in each step that loads the
//   output register until that register frees up.
`default_nettype none

module sparse_index_set_merge_core
  import sism_pkg::*;
#(
  parameter int INDEX_RANGE = 1024,
  parameter int MAX_MEMBERS = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  // local_count
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [LC_W-1:0] cfg_data,
  // command stream
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [15:0]     s_tdata,   // [2:0] operation, [12:3] index, rest zero
  input  wire logic            s_tlast,   // list_end
  // result stream
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [31:0]          m_tdata,   // [9:0] index_out, [12:10] status,
                                          // [19:13] run_length, [26:20] pattern_length
  output logic                 m_tlast    // last
);

  localparam int MARK_DEPTH = (INDEX_RANGE < IDX_SPAN) ? INDEX_RANGE : IDX_SPAN;
  localparam int MARK_AW    = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int LIST_AW    = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MERGE_CHK, S_CLR_RD, S_CLR_WR, S_RUN_RD, S_RUN_OUT, S_RESULT
  } state_t;

  state_t            state;
  logic [LC_W-1:0]   local_count;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  level;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  run_len;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  res_index;
  logic [ST_W-1:0]   res_status;
  logic [CNT_W-1:0]  res_run;
  logic              res_last;

  logic              out_valid;
  logic [IDX_W-1:0]  out_index;
  logic [ST_W-1:0]   out_status;
  logic [CNT_W-1:0]  out_run;
  logic [CNT_W-1:0]  out_plen;
  logic              out_last;

  logic [IDX_W-1:0]  list_mem [MAX_MEMBERS];
  logic [IDX_W-1:0]  list_rd;

  mark_cmd_t         mcmd;
  logic [MARK_AW-1:0] maddr;
  logic              mhit;
  logic              mbusy;

  logic [OP_W-1:0]   in_op;
  logic [IDX_W-1:0]  in_idx;
  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic              is_local;
  logic              out_of_range;
  logic              list_full;
  logic              do_insert;
  logic [CNT_W-1:0]  run_from;
  logic              pos_last;

  assign in_op    = s_tdata[OP_W-1:0];
  assign in_idx   = s_tdata[OP_W +: IDX_W];
  assign s_tready = (state == S_IDLE) && !mbusy;
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign out_load = (state == S_RUN_OUT || state == S_RESULT) && out_free;
  assign cfg_ready = 1'b1;

  assign is_local     = (in_op == OP_EXT_MERGE) && ({1'b0, in_idx} < local_count);
  assign out_of_range = {7'd0, in_idx} >= 17'(INDEX_RANGE);
  assign list_full    = (count == CNT_W'(MAX_MEMBERS));
  assign do_insert    = (state == S_MERGE_CHK) && !mhit && !list_full;
  assign run_from     = (in_op == OP_READ_NEW) ? level : '0;
  assign pos_last     = ((pos + CNT_W'(1)) == count);

  // marker memory access
  always_comb begin
    mcmd  = '0;
    maddr = idx_r[MARK_AW-1:0];
    case (state)
      S_IDLE: begin
        maddr   = in_idx[MARK_AW-1:0];
        mcmd.rd = in_acc && (in_op == OP_MERGE || in_op == OP_EXT_MERGE);
      end
      S_MERGE_CHK: begin
        mcmd.wr  = do_insert;
        mcmd.set = 1'b1;
      end
      S_CLR_WR: begin
        maddr   = list_rd[MARK_AW-1:0];
        mcmd.wr = 1'b1;
      end
      default: ;
    endcase
  end

  sism_marker #(
    .DEPTH (MARK_DEPTH),
    .AW    (MARK_AW)
  ) u_marker (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mcmd),
    .addr (maddr),
    .hit  (mhit),
    .busy (mbusy)
  );

  // member list
  always_ff @(posedge clk) begin
    if (do_insert) begin
      list_mem[count[LIST_AW-1:0]] <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLR_RD || state == S_RUN_RD) begin
      list_rd <= list_mem[pos[LIST_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      local_count <= '0;
      count       <= '0;
      level       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        local_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            idx_r  <= in_idx;
            case (in_op)
              OP_MERGE, OP_EXT_MERGE: begin
                res_index <= in_idx;
                res_run   <= '0;
                res_last  <= s_tlast;
                if (is_local) begin
                  res_status <= ST_LOCAL;
                  state      <= S_RESULT;
                end else if (out_of_range) begin
                  res_status <= ST_RANGE;
                  state      <= S_RESULT;
                end else begin
                  state <= S_MERGE_CHK;
                end
              end
              OP_RESET: begin
                pos <= '0;
                if (count == '0) begin
                  level      <= '0;
                  res_index  <= '0;
                  res_status <= ST_RESET;
                  res_run    <= '0;
                  res_last   <= 1'b1;
                  state      <= S_RESULT;
                end else begin
                  state <= S_CLR_RD;
                end
              end
              OP_READ_ALL, OP_READ_NEW: begin
                if (in_op == OP_READ_NEW) begin
                  level <= count;
                end
                if (count <= run_from) begin
                  res_index  <= '0;
                  res_status <= ST_EMPTY;
                  res_run    <= '0;
                  res_last   <= 1'b1;
                  state      <= S_RESULT;
                end else begin
                  pos     <= run_from;
                  run_len <= count - run_from;
                  state   <= S_RUN_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_MERGE_CHK: begin
          if (mhit) begin
            res_status <= ST_PRESENT;
          end else if (list_full) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_INSERTED;
            count      <= count + CNT_W'(1);
          end
          state <= S_RESULT;
        end
        S_CLR_RD: begin
          state <= S_CLR_WR;
        end
        S_CLR_WR: begin
          if (pos_last) begin
            count      <= '0;
            level      <= '0;
            res_index  <= '0;
            res_status <= ST_RESET;
            res_run    <= '0;
            res_last   <= 1'b1;
            state      <= S_RESULT;
          end else begin
            pos   <= pos + CNT_W'(1);
            state <= S_CLR_RD;
          end
        end
        S_RUN_RD: begin
          state <= S_RUN_OUT;
        end
        S_RUN_OUT: begin
          if (out_free) begin
            out_index  <= list_rd;
            out_status <= ST_ENTRY;
            out_run    <= run_len;
            out_plen   <= count;
            out_last   <= pos_last;
            if (pos_last) begin
              state <= S_IDLE;
            end else begin
              pos   <= pos + CNT_W'(1);
              state <= S_RUN_RD;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_index  <= res_index;
            out_status <= res_status;
            out_run    <= res_run;
            out_plen   <= count;
            out_last   <= res_last;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_plen, out_run, out_status, out_index};
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

// File: hdl/sism_marker.sv
`timescale 1ns / 1ps
// Marker memory: one membership bit per index, with a clearing pass after reset.
// Depends on sism_pkg.
`default_nettype none

module sism_marker
  import sism_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mark_cmd_t     cmd,
  input  wire logic [AW-1:0] addr,
  output logic               hit,
  output logic               busy
);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;

  // sweep every entry to empty after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (cmd.wr) begin
      mem[addr] <= cmd.set;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      hit <= mem[addr];
    end
  end

endmodule

`default_nettype wire
